>>> hdl/mexp_pkg.sv
package mexp_pkg;

    localparam int DATA_W        = 32;
    localparam int MOD_WIDTH_DEF = 32;
    localparam int EXP_WIDTH_DEF = 32;
    localparam int CNT_W         = $clog2(DATA_W + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_TEST,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load_in;
        logic step;
        logic start_mul;
        logic mul_sq;
        logic wb_acc;
        logic wb_sq;
        logic shift_e;
        logic clr_acc;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic sq_zero;
        logic e_zero;
        logic e_lsb;
        logic e_hi_zero;
        logic out_free;
    } status_t;

endpackage

>>> hdl/mexp_in_if.sv
interface mexp_in_if;

    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::DATA_W-1:0] base;
    logic [mexp_pkg::DATA_W-1:0] exponent;

    modport source (output valid, output base, output exponent, input ready);
    modport sink   (input valid, input base, input exponent, output ready);

endinterface

>>> hdl/mexp_out_if.sv
interface mexp_out_if;

    logic                        valid;
    logic                        ready;
    logic [mexp_pkg::DATA_W-1:0] power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);

endinterface

>>> hdl/mexp_ctrl.sv
module mexp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mexp_pkg::status_t sts,
    output mexp_pkg::cmd_t    cmd
);

    mexp_pkg::state_t state_reg;
    mexp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mexp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = mexp_pkg::ST_RED;
                end
            end
            mexp_pkg::ST_RED:
            begin
                if (sts.cnt_zero)
                begin
                    cmd.wb_sq  = 1'b1;
                    state_next = mexp_pkg::ST_TEST;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            mexp_pkg::ST_TEST:
            begin
                if (sts.sq_zero)
                begin
                    cmd.clr_acc = 1'b1;
                    state_next  = mexp_pkg::ST_FIN;
                end
                else
                begin
                    state_next = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_CHECK:
            begin
                priority if (sts.e_zero)
                begin
                    state_next = mexp_pkg::ST_FIN;
                end
                else if (sts.e_lsb)
                begin
                    cmd.start_mul = 1'b1;
                    state_next    = mexp_pkg::ST_MUL;
                end
                else
                begin
                    cmd.start_mul = 1'b1;
                    cmd.mul_sq    = 1'b1;
                    state_next    = mexp_pkg::ST_SQR;
                end
            end
            mexp_pkg::ST_MUL:
            begin
                if (sts.cnt_zero)
                begin
                    cmd.wb_acc = 1'b1;
                    if (sts.e_hi_zero)
                    begin
                        state_next = mexp_pkg::ST_FIN;
                    end
                    else
                    begin
                        cmd.start_mul = 1'b1;
                        cmd.mul_sq    = 1'b1;
                        state_next    = mexp_pkg::ST_SQR;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            mexp_pkg::ST_SQR:
            begin
                if (sts.cnt_zero)
                begin
                    cmd.wb_sq   = 1'b1;
                    cmd.shift_e = 1'b1;
                    state_next  = mexp_pkg::ST_CHECK;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            mexp_pkg::ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_mul_needs_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.start_mul && state_reg == mexp_pkg::ST_CHECK) |-> !sts.e_zero)
        else $error("multiply started with zero exponent");
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == mexp_pkg::ST_RED)
        else $error("accepted transaction did not start reduction");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded into busy output register");
`endif

endmodule

>>> hdl/mexp_dpath.sv
module mexp_dpath #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [mexp_pkg::DATA_W-1:0] wr_data,
    input  logic [mexp_pkg::DATA_W-1:0] base,
    input  logic [mexp_pkg::DATA_W-1:0] exponent,
    input  mexp_pkg::cmd_t              cmd,
    output mexp_pkg::status_t           sts,
    mexp_out_if.source                  result
);

    localparam int DW = mexp_pkg::DATA_W;
    localparam int CW = mexp_pkg::CNT_W;

    logic [MOD_WIDTH-1:0] mod_reg;
    logic [MOD_WIDTH-1:0] m_eff;
    logic [MOD_WIDTH:0]   m_ext;
    logic [EXP_WIDTH-1:0] e_reg;
    logic [MOD_WIDTH-1:0] sq_reg;
    logic [MOD_WIDTH-1:0] acc_reg;
    logic [MOD_WIDTH-1:0] r_reg;
    logic [MOD_WIDTH-1:0] a_reg;
    logic [DW-1:0]        b_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 mul_mode_reg;
    logic                 out_valid_reg;
    logic [DW-1:0]        power_reg;

    logic [MOD_WIDTH:0]   red_sh;
    logic [MOD_WIDTH:0]   red_r;
    logic [MOD_WIDTH:0]   dbl;
    logic [MOD_WIDTH:0]   dbl_r;
    logic [MOD_WIDTH:0]   add;
    logic [MOD_WIDTH:0]   add_r;
    logic [MOD_WIDTH-1:0] step_r;
    logic [MOD_WIDTH-1:0] mul_b;

    assign m_eff = (mod_reg == '0) ? MOD_WIDTH'(1) : mod_reg;
    assign m_ext = {1'b0, m_eff};

    // restoring remainder step for the base
    assign red_sh = {r_reg, b_reg[DW-1]};
    assign red_r  = (red_sh >= m_ext) ? red_sh - m_ext : red_sh;

    // interleaved multiply step: r = 2r + bit*a mod m
    assign dbl   = {r_reg, 1'b0};
    assign dbl_r = (dbl >= m_ext) ? dbl - m_ext : dbl;
    assign add   = dbl_r + (b_reg[DW-1] ? {1'b0, a_reg} : '0);
    assign add_r = (add >= m_ext) ? add - m_ext : add;

    assign step_r = mul_mode_reg ? add_r[MOD_WIDTH-1:0] : red_r[MOD_WIDTH-1:0];
    assign mul_b  = cmd.mul_sq ? sq_reg : acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg       <= MOD_WIDTH'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                mod_reg <= MOD_WIDTH'(wr_data);
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            e_reg        <= EXP_WIDTH'(exponent);
            b_reg        <= base;
            r_reg        <= '0;
            cnt_reg      <= CW'(DW);
            acc_reg      <= MOD_WIDTH'(1);
            mul_mode_reg <= 1'b0;
        end
        else
        begin
            if (cmd.step)
            begin
                r_reg   <= step_r;
                b_reg   <= b_reg << 1;
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.wb_sq)
            begin
                sq_reg <= r_reg;
            end
            if (cmd.wb_acc)
            begin
                acc_reg <= r_reg;
            end
            if (cmd.clr_acc)
            begin
                acc_reg <= '0;
            end
            if (cmd.shift_e)
            begin
                e_reg <= e_reg >> 1;
            end
            if (cmd.start_mul)
            begin
                a_reg        <= sq_reg;
                b_reg        <= DW'(mul_b) << (DW - MOD_WIDTH);
                r_reg        <= '0;
                cnt_reg      <= CW'(MOD_WIDTH);
                mul_mode_reg <= 1'b1;
            end
        end
        if (cmd.load_out)
        begin
            power_reg <= DW'(acc_reg);
        end
    end

    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.sq_zero   = (sq_reg == '0);
    assign sts.e_zero    = (e_reg == '0);
    assign sts.e_lsb     = e_reg[0];
    assign sts.e_hi_zero = ((e_reg >> 1) == '0);
    assign sts.out_free  = !out_valid_reg || result.ready;

    assign result.valid = out_valid_reg;
    assign result.power = power_reg;

`ifndef ASSERT_OFF
    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> cnt_reg != '0)
        else $error("step issued with exhausted bit counter");
    a_out_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("output register not marked valid");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready) |=> $stable(power_reg))
        else $error("pending result overwritten");
`endif

endmodule

>>> hdl/modular_exponentiation.sv
// channel  | role   | payload
// operand  | sink   | base[31:0], exponent[31:0]
// result   | source | power[31:0]
// wr_en    | config | wr_data[31:0] -> modulus
//
// base reduction: 32 remainder steps, then a write-back of the reduced base
// each exponent bit passes a check state and up to two modular multiplies (multiply, then square),
// run on the single bit-serial shift-add-reduce multiplier
// one transaction at a time; the next is taken while a result waits in the output register
// rst_n is asynchronous; modulus resets to 1, control and output valid clear
// a stalled result stalls only the final load, never the running computation
module modular_exponentiation #(
    parameter int MOD_WIDTH = mexp_pkg::MOD_WIDTH_DEF,
    parameter int EXP_WIDTH = mexp_pkg::EXP_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [mexp_pkg::DATA_W-1:0] wr_data,
    mexp_in_if.sink                     operand,
    mexp_out_if.source                  result
);

    mexp_pkg::cmd_t    cmd;
    mexp_pkg::status_t sts;
    logic              in_ready;

    assign operand.ready = in_ready;

    mexp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (operand.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mexp_dpath #(
        .MOD_WIDTH (MOD_WIDTH),
        .EXP_WIDTH (EXP_WIDTH)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .base     (operand.base),
        .exponent (operand.exponent),
        .cmd      (cmd),
        .sts      (sts),
        .result   (result)
    );

endmodule

>>> test/modular_exponentiation_tb.sv
module modular_exponentiation_tb;

    localparam int DATA_W        = mexp_pkg::DATA_W;
    localparam int IDLE_LIMIT    = 12000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 33;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct {
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] exponent;
    } operation_t;

    logic              clk;
    logic              rst_n;
    logic              wr_en;
    logic [DATA_W-1:0] wr_data;

    mexp_in_if  operand_if ();
    mexp_out_if result_if ();

    operation_t        pending_operations[$];
    logic [DATA_W-1:0] expected_powers[$];
    logic [DATA_W-1:0] current_modulus;
    operation_t        next_operation;
    logic [DATA_W-1:0] wanted_power;
    int                fail_count;
    int                burst_left;
    int                gap_left;
    int                stall_mode;
    int                mode_cycles;
    int                quiet_cycles;

    modular_exponentiation uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .operand (operand_if),
        .result  (result_if)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // square-and-multiply, least significant exponent bit first
    function automatic logic [DATA_W-1:0] modpow(logic [DATA_W-1:0] b, logic [DATA_W-1:0] e,
                                                  logic [DATA_W-1:0] m);
        logic [63:0]       mm;
        logic [63:0]       sq;
        logic [63:0]       acc;
        logic [DATA_W-1:0] bits;
        mm   = (m == '0) ? 64'd1 : {32'd0, m};
        sq   = {32'd0, b} % mm;
        bits = e;
        acc  = 64'd1;
        if (sq == 64'd0)
        begin
            return '0;
        end
        while (bits != '0)
        begin
            if (bits[0])
            begin
                acc = (acc * sq) % mm;
            end
            bits = bits >> 1;
            sq   = (sq * sq) % mm;
        end
        return acc[DATA_W-1:0];
    endfunction

    function automatic operation_t random_operation(logic [DATA_W-1:0] m);
        operation_t op;
        case ($urandom_range(0, 9))
            0: op.base = m * $urandom_range(0, 3);
            1: op.base = $urandom_range(0, 15);
            2: op.base = m - $urandom_range(1, 3);
            3: op.base = $urandom >> $urandom_range(1, 31);
            default: op.base = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0: op.exponent = $urandom_range(0, 2);
            1, 2: op.exponent = $urandom >> $urandom_range(1, 31);
            3: op.exponent = 32'hFFFF_FFFF;
            default: op.exponent = $urandom;
        endcase
        return op;
    endfunction

    task automatic push_operation(logic [DATA_W-1:0] b, logic [DATA_W-1:0] e);
        operation_t op;
        op.base     = b;
        op.exponent = e;
        pending_operations.push_back(op);
    endtask

    task automatic drain();
        while (pending_operations.size() != 0 || expected_powers.size() != 0 || operand_if.valid)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_modulus(logic [DATA_W-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        wr_en   <= 1'b1;
        wr_data <= value;
        @(posedge clk);
        wr_en   <= 1'b0;
        current_modulus = value;
        @(negedge clk);
    endtask

    // driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand_if.valid    <= 1'b0;
            operand_if.base     <= '0;
            operand_if.exponent <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!operand_if.valid || operand_if.ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                operand_if.valid <= 1'b0;
            end
            else if (pending_operations.size() != 0)
            begin
                next_operation = pending_operations.pop_front();
                operand_if.valid    <= 1'b1;
                operand_if.base     <= next_operation.base;
                operand_if.exponent <= next_operation.exponent;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 7);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
            begin
                operand_if.valid <= 1'b0;
            end
        end
    end

    // monitor: checks results first, then records the expectation for a new transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_if.ready <= 1'b0;
            stall_mode  = 0;
            mode_cycles = 0;
        end
        else
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("unexpected transaction: power actual %h", result_if.power);
                    fail_count++;
                end
                else
                begin
                    wanted_power = expected_powers.pop_front();
                    if (result_if.power !== wanted_power)
                    begin
                        $error("power mismatch: expected %h, actual %h",
                               wanted_power, result_if.power);
                        fail_count++;
                    end
                end
            end
            if (operand_if.valid && operand_if.ready)
            begin
                expected_powers.push_back(modpow(operand_if.base, operand_if.exponent,
                                                 current_modulus));
            end
            if (mode_cycles == 0)
            begin
                stall_mode  = $urandom_range(0, 2);
                mode_cycles = $urandom_range(50, 3000);
            end
            else
            begin
                mode_cycles--;
            end
            case (stall_mode)
                0: result_if.ready <= 1'b1;
                1: result_if.ready <= $urandom_range(0, 1);
                default: result_if.ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((operand_if.valid && operand_if.ready) || (result_if.valid && result_if.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin
        logic [DATA_W-1:0] phase_moduli[RANDOM_PHASES];
        rst_n           = 1'b0;
        wr_en           = 1'b0;
        wr_data         = '0;
        current_modulus = 32'd1;
        fail_count      = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // modulus left at its reset value of one
        push_operation(32'd0, 32'd0);
        push_operation(32'd5, 32'd3);
        push_operation(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        set_modulus(32'hFFFF_FFFF);
        push_operation(32'd0, 32'd0);
        push_operation(32'hFFFF_FFFF, 32'd5);
        push_operation(32'd2, 32'd0);
        push_operation(32'd2, 32'd1);
        push_operation(32'd1, 32'hFFFF_FFFF);
        push_operation(32'd3, 32'd31);
        push_operation(32'd7, 32'h8000_0000);
        push_operation(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        push_operation(32'h1234_5678, 32'hFFFF_FFFF);

        // zero modulus behaves as a modulus of one
        set_modulus(32'd0);
        push_operation(32'd5, 32'd3);
        push_operation(32'd0, 32'd0);

        set_modulus(32'd2);
        push_operation(32'd3, 32'd0);
        push_operation(32'd2, 32'd7);
        push_operation(32'd1, 32'd9);

        set_modulus(32'hFFFF_FFFB);
        push_operation(32'hFFFF_FFFB, 32'd0);
        push_operation(32'hFFFF_FFFC, 32'hFFFF_FFFA);
        push_operation(32'd2, 32'hFFFF_FFFA);

        phase_moduli[0] = 32'hFFFF_FFFF;
        phase_moduli[1] = 32'd1;
        phase_moduli[2] = 32'd3;
        phase_moduli[3] = 32'h8000_0000;
        phase_moduli[4] = 32'd65537;
        phase_moduli[5] = $urandom | 32'h8000_0001;
        phase_moduli[6] = $urandom_range(2, 65535);
        phase_moduli[7] = 32'hFFFF_FFFB;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_modulus(phase_moduli[p]);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pending_operations.push_back(random_operation(current_modulus));
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_powers.size() != 0)
        begin
            $error("%0d transactions never produced a power", expected_powers.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
